FILE: rtl/core/assert_macros.svh
// Assertion macros used by the decoder top level to check its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/core/hbad_pkg.sv
// Package with the types and constants of the bus address decoder.
`default_nettype none

package hbad_pkg;

   // Access size codes.
   localparam logic [1:0] SIZE_BYTE = 2'd0;
   localparam logic [1:0] SIZE_HALF = 2'd1;
   localparam logic [1:0] SIZE_WORD = 2'd2;

   // Region codes.
   localparam logic [4:0] RG_BIOS     = 5'd0;
   localparam logic [4:0] RG_EWRAM    = 5'd1;
   localparam logic [4:0] RG_IWRAM    = 5'd2;
   localparam logic [4:0] RG_VIDEO    = 5'd3;
   localparam logic [4:0] RG_DMA      = 5'd4;
   localparam logic [4:0] RG_TIMER    = 5'd5;
   localparam logic [4:0] RG_KEYPAD   = 5'd6;
   localparam logic [4:0] RG_SERIAL   = 5'd7;
   localparam logic [4:0] RG_INTR     = 5'd8;
   localparam logic [4:0] RG_POWER    = 5'd9;
   localparam logic [4:0] RG_MEMCTL   = 5'd10;
   localparam logic [4:0] RG_UNMAPPED = 5'd11;
   localparam logic [4:0] RG_PALETTE  = 5'd12;
   localparam logic [4:0] RG_VRAM     = 5'd13;
   localparam logic [4:0] RG_OAM      = 5'd14;
   localparam logic [4:0] RG_ROM      = 5'd15;
   localparam logic [4:0] RG_SRAM     = 5'd16;

   // Address page codes taken from address bits 27:24.
   localparam logic [3:0] PG_BIOS    = 4'h0;
   localparam logic [3:0] PG_EWRAM   = 4'h2;
   localparam logic [3:0] PG_IWRAM   = 4'h3;
   localparam logic [3:0] PG_IO      = 4'h4;
   localparam logic [3:0] PG_PALETTE = 4'h5;
   localparam logic [3:0] PG_VRAM    = 4'h6;
   localparam logic [3:0] PG_OAM     = 4'h7;
   localparam logic [3:0] PG_ROM0A   = 4'h8;
   localparam logic [3:0] PG_ROM0B   = 4'h9;
   localparam logic [3:0] PG_ROM1A   = 4'hA;
   localparam logic [3:0] PG_ROM1B   = 4'hB;
   localparam logic [3:0] PG_ROM2A   = 4'hC;
   localparam logic [3:0] PG_ROM2B   = 4'hD;
   localparam logic [3:0] PG_SRAMA   = 4'hE;
   localparam logic [3:0] PG_SRAMB   = 4'hF;

   // I/O space boundaries, as offsets inside the I/O page.
   localparam logic [23:0] IO_VIDEO_LAST = 24'h000056;
   localparam logic [23:0] IO_DMA_FIRST  = 24'h0000B0;
   localparam logic [23:0] IO_DMA_LAST   = 24'h0000DE;
   localparam logic [23:0] IO_TIMER_FIRST = 24'h000100;
   localparam logic [23:0] IO_TIMER_LAST = 24'h00010F;
   localparam logic [23:0] IO_KEYPAD     = 24'h000130;
   localparam logic [23:0] IO_SERIAL     = 24'h000134;
   localparam logic [23:0] IO_HIGH_FIRST = 24'h000200;
   localparam logic [3:0]  IO_SEL_INTR   = 4'h2;
   localparam logic [3:0]  IO_SEL_POWER  = 4'h3;
   localparam logic [15:0] IO_MEMCTL_LOW = 16'h0800;
   localparam logic [27:0] IRQ_FLAG_ADDR = 28'h4000202;
   localparam logic [7:0]  DMA_STRIDE    = 8'd12;

   // Mirror masks of the memory regions.
   localparam logic [24:0] MASK_BIOS    = 25'h0FFFFFF;
   localparam logic [24:0] MASK_EWRAM   = 25'h003FFFF;
   localparam logic [24:0] MASK_IWRAM   = 25'h0007FFF;
   localparam logic [24:0] MASK_SMALL   = 25'h00003FF;
   localparam logic [24:0] MASK_VRAM    = 25'h001FFFF;
   localparam logic [24:0] MASK_SRAM    = 25'h000FFFF;

   // One bus access.
   typedef struct packed {
      logic [31:0] address;
      logic [1:0]  access_size;
      logic        action;
      logic [15:0] write_data;
   } req_type;

   // One decode result.
   typedef struct packed {
      logic [4:0]  region;
      logic [24:0] offset;
      logic [1:0]  dma_channel;
      logic [1:0]  wait_state;
      logic        allowed;
      logic [15:0] irq_clear_mask;
   } rsp_type;

endpackage

`default_nettype wire

FILE: rtl/core/hbad_if.sv
// Handshake channel interfaces for bus access requests and decode results.
`default_nettype none

interface hbad_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] address;
   logic [1:0]  access_size;
   logic        action;
   logic [15:0] write_data;

   modport source (output valid, address, access_size, action, write_data, input ready);
   modport sink (input valid, address, access_size, action, write_data, output ready);
endinterface

interface hbad_rsp_if;
   logic        valid;
   logic        ready;
   logic [4:0]  region;
   logic [24:0] offset;
   logic [1:0]  dma_channel;
   logic [1:0]  wait_state;
   logic        allowed;
   logic [15:0] irq_clear_mask;

   modport source (output valid, region, offset, dma_channel, wait_state, allowed,
                   irq_clear_mask, input ready);
   modport sink (input valid, region, offset, dma_channel, wait_state, allowed,
                 irq_clear_mask, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/hbad_decode.sv
// Combinational decode of one bus access into region, offset and permissions.
`default_nettype none

module hbad_decode (
   input  wire hbad_pkg::req_type req_in,
   output hbad_pkg::rsp_type      rsp_out
);

   logic [31:0] addr_al;
   logic [27:0] addr;
   logic [23:0] io_off;
   logic [7:0]  dma_diff;
   logic [1:0]  dma_chan;
   logic [7:0]  dma_base;
   logic        is_byte;
   logic        is_wr;

   // Word accesses drop the two low address bits; size 3 counts as a word.
   assign is_byte = (req_in.access_size == hbad_pkg::SIZE_BYTE);
   assign is_wr   = req_in.action;
   assign addr_al = (req_in.access_size[1]) ? {req_in.address[31:2], 2'b00} : req_in.address;
   assign addr    = addr_al[27:0];
   assign io_off  = addr[23:0];

   // DMA channel from the distance to the first DMA register, twelve bytes a channel.
   assign dma_diff = io_off[7:0] - hbad_pkg::IO_DMA_FIRST[7:0];
   always_comb begin
      if (dma_diff < hbad_pkg::DMA_STRIDE) begin
         dma_chan = 2'd0;
      end else if (dma_diff < 8'(2 * hbad_pkg::DMA_STRIDE)) begin
         dma_chan = 2'd1;
      end else if (dma_diff < 8'(3 * hbad_pkg::DMA_STRIDE)) begin
         dma_chan = 2'd2;
      end else begin
         dma_chan = 2'd3;
      end
   end
   assign dma_base = 8'(dma_chan * hbad_pkg::DMA_STRIDE);

   // Region selection by address bits 27:24, then the finer split of the I/O page.
   always_comb begin
      rsp_out = '0;
      rsp_out.region = hbad_pkg::RG_UNMAPPED;
      case (addr[27:24])
         hbad_pkg::PG_BIOS: begin
            rsp_out.region  = hbad_pkg::RG_BIOS;
            rsp_out.offset  = addr[24:0] & hbad_pkg::MASK_BIOS;
            rsp_out.allowed = !is_wr;
         end
         hbad_pkg::PG_EWRAM: begin
            rsp_out.region  = hbad_pkg::RG_EWRAM;
            rsp_out.offset  = addr[24:0] & hbad_pkg::MASK_EWRAM;
            rsp_out.allowed = 1'b1;
         end
         hbad_pkg::PG_IWRAM: begin
            rsp_out.region  = hbad_pkg::RG_IWRAM;
            rsp_out.offset  = addr[24:0] & hbad_pkg::MASK_IWRAM;
            rsp_out.allowed = 1'b1;
         end
         hbad_pkg::PG_IO: begin
            rsp_out.allowed = 1'b1;
            if (is_wr && addr == hbad_pkg::IRQ_FLAG_ADDR) begin
               rsp_out.region = hbad_pkg::RG_INTR;
               rsp_out.offset = 25'(hbad_pkg::IRQ_FLAG_ADDR[7:0]);
               rsp_out.irq_clear_mask = is_byte ? {8'h00, req_in.write_data[7:0]}
                                                : req_in.write_data;
            end else if (io_off <= hbad_pkg::IO_VIDEO_LAST) begin
               rsp_out.region = hbad_pkg::RG_VIDEO;
               rsp_out.offset = {1'b0, io_off};
            end else if (io_off >= hbad_pkg::IO_DMA_FIRST && io_off <= hbad_pkg::IO_DMA_LAST) begin
               rsp_out.region      = hbad_pkg::RG_DMA;
               rsp_out.dma_channel = dma_chan;
               rsp_out.offset      = 25'(dma_diff - dma_base);
            end else if (io_off >= hbad_pkg::IO_TIMER_FIRST &&
                         io_off <= hbad_pkg::IO_TIMER_LAST) begin
               rsp_out.region = hbad_pkg::RG_TIMER;
               rsp_out.offset = 25'(io_off[3:0]);
            end else if (io_off == hbad_pkg::IO_KEYPAD) begin
               rsp_out.region = hbad_pkg::RG_KEYPAD;
            end else if (io_off == hbad_pkg::IO_SERIAL) begin
               rsp_out.region = hbad_pkg::RG_SERIAL;
            end else if (io_off >= hbad_pkg::IO_HIGH_FIRST) begin
               if (io_off[11:8] == hbad_pkg::IO_SEL_INTR) begin
                  rsp_out.region = hbad_pkg::RG_INTR;
                  rsp_out.offset = 25'(io_off[7:0]);
               end else if (io_off[11:8] == hbad_pkg::IO_SEL_POWER) begin
                  rsp_out.region = hbad_pkg::RG_POWER;
                  rsp_out.offset = 25'(io_off[7:0]);
               end else if (io_off[15:0] == hbad_pkg::IO_MEMCTL_LOW) begin
                  rsp_out.region = hbad_pkg::RG_MEMCTL;
               end
            end
         end
         hbad_pkg::PG_PALETTE: begin
            rsp_out.region  = hbad_pkg::RG_PALETTE;
            rsp_out.offset  = addr[24:0] & hbad_pkg::MASK_SMALL;
            rsp_out.allowed = !(is_wr && is_byte);
         end
         hbad_pkg::PG_VRAM: begin
            rsp_out.region  = hbad_pkg::RG_VRAM;
            rsp_out.offset  = addr[24:0] & hbad_pkg::MASK_VRAM;
            rsp_out.allowed = !(is_wr && is_byte);
         end
         hbad_pkg::PG_OAM: begin
            rsp_out.region  = hbad_pkg::RG_OAM;
            rsp_out.offset  = addr[24:0] & hbad_pkg::MASK_SMALL;
            rsp_out.allowed = !(is_wr && is_byte);
         end
         hbad_pkg::PG_ROM0A, hbad_pkg::PG_ROM0B, hbad_pkg::PG_ROM1A,
         hbad_pkg::PG_ROM1B, hbad_pkg::PG_ROM2A, hbad_pkg::PG_ROM2B: begin
            // Each ROM window spans two pages, so the offset keeps bit 24.
            rsp_out.region     = hbad_pkg::RG_ROM;
            rsp_out.offset     = addr[24:0];
            rsp_out.wait_state = addr[26:25];
            rsp_out.allowed    = !is_wr;
         end
         hbad_pkg::PG_SRAMA, hbad_pkg::PG_SRAMB: begin
            rsp_out.region  = hbad_pkg::RG_SRAM;
            rsp_out.offset  = addr[24:0] & hbad_pkg::MASK_SRAM;
            rsp_out.allowed = is_byte;
         end
         default: begin
            rsp_out.region  = hbad_pkg::RG_UNMAPPED;
            rsp_out.allowed = 1'b0;
         end
      endcase
   end

endmodule

`default_nettype wire

FILE: rtl/core/handheld_bus_address_decoder.sv
// A request goes from acceptance through the input register and then the result register.
// One request per cycle while results are taken; a stall holds one more in the input stage.
// The whole decode is one pass of combinational logic between the two registers.
// Reset is synchronous and active high; it empties both stages and holds no other state.
// Top level of the bus address decoder.
`default_nettype none
`include "assert_macros.svh"

module handheld_bus_address_decoder (
   input  wire  clock,
   input  wire  reset,
   hbad_req_if.sink   req_bus,
   hbad_rsp_if.source rsp_bus
);

   logic              in_valid_ff;
   logic              in_valid_in;
   hbad_pkg::req_type in_data_ff;
   logic              out_valid_ff;
   logic              out_valid_in;
   hbad_pkg::rsp_type out_data_ff;
   hbad_pkg::rsp_type dec_rsp;
   logic              out_load;
   logic              in_load;

   // The result register loads when it is empty or being drained.
   assign out_load = !out_valid_ff || rsp_bus.ready;
   assign in_load  = !in_valid_ff || out_load;
   assign req_bus.ready = in_load;

   assign in_valid_in  = in_load ? req_bus.valid : in_valid_ff;
   assign out_valid_in = out_load ? in_valid_ff : out_valid_ff;

   // Input register holds the accepted request.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (in_load) begin
         in_data_ff.address     <= req_bus.address;
         in_data_ff.access_size <= req_bus.access_size;
         in_data_ff.action      <= req_bus.action;
         in_data_ff.write_data  <= req_bus.write_data;
      end
   end

   hbad_decode u_decode (
      .req_in  (in_data_ff),
      .rsp_out (dec_rsp)
   );

   // Result register holds the decoded request until it is taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      if (out_load) begin
         out_data_ff <= dec_rsp;
      end
   end

   assign rsp_bus.valid          = out_valid_ff;
   assign rsp_bus.region         = out_data_ff.region;
   assign rsp_bus.offset         = out_data_ff.offset;
   assign rsp_bus.dma_channel    = out_data_ff.dma_channel;
   assign rsp_bus.wait_state     = out_data_ff.wait_state;
   assign rsp_bus.allowed        = out_data_ff.allowed;
   assign rsp_bus.irq_clear_mask = out_data_ff.irq_clear_mask;

   // A request waiting behind a stalled result must still be there next cycle.
   `ASSERT_NEXT(a_no_drop, in_valid_ff && out_valid_ff && !rsp_bus.ready, in_valid_ff, "request lost behind stalled result")
   // Only the interrupt control region carries a clear mask.
   `ASSERT_IMPLIES(a_mask_region, out_valid_ff && out_data_ff.irq_clear_mask != 16'h0000, out_data_ff.region == hbad_pkg::RG_INTR, "clear mask outside interrupt region")
   // A wait-state index belongs to ROM only.
   `ASSERT_IMPLIES(a_ws_rom, out_valid_ff && out_data_ff.wait_state != 2'd0, out_data_ff.region == hbad_pkg::RG_ROM, "wait state outside ROM")
   // Unmapped space always reports offset zero.
   `ASSERT_IMPLIES(a_unmapped_off, out_valid_ff && out_data_ff.region == hbad_pkg::RG_UNMAPPED, out_data_ff.offset == 25'd0, "nonzero offset in unmapped space")

endmodule

`default_nettype wire

FILE: tb/tb_handheld_bus_address_decoder.sv
// Self-checking testbench for the bus address decoder: directed table, then random accesses.
`timescale 1ns / 1ps

module tb_handheld_bus_address_decoder;

   // Direction codes of a bus access, and the size code that decodes as a word.
   localparam logic ACT_READ = 1'b0;
   localparam logic ACT_WRITE = 1'b1;
   localparam logic [1:0] SIZE_SPARE = 2'd3;

   localparam int unsigned RANDOM_ITEMS = 500;
   localparam int unsigned DRAIN_AT = 200;
   localparam int unsigned HOLDOFF_AT = 120;
   localparam int unsigned HOLDOFF_CYCLES = 64;
   localparam int unsigned STEADY_FIRST = 300;
   localparam int unsigned STEADY_LAST = 380;
   localparam int unsigned IDLE_PERCENT = 37;
   localparam int unsigned MAX_REPORTS = 10;
   localparam int unsigned TAIL_CYCLES = 10;
   localparam int unsigned CYCLE_LIMIT = 200000;

   // One row of the directed table; golden is used only where known is set.
   typedef struct packed {
      hbad_pkg::req_type req;
      logic              known;
      hbad_pkg::rsp_type golden;
   } vector_row_type;

   localparam hbad_pkg::rsp_type NO_GOLDEN = '0;

   localparam vector_row_type DIRECTED [0:25] = '{
      // Lowest address, highest address, undecoded page, interrupt clears, ROM extremes.
      '{'{32'h00000000, hbad_pkg::SIZE_BYTE, ACT_READ, 16'h0000}, 1'b1,
        '{hbad_pkg::RG_BIOS, 25'h0000000, 2'd0, 2'd0, 1'b1, 16'h0000}},
      '{'{32'hFFFFFFFF, hbad_pkg::SIZE_WORD, ACT_WRITE, 16'hFFFF}, 1'b1,
        '{hbad_pkg::RG_SRAM, 25'h000FFFC, 2'd0, 2'd0, 1'b0, 16'h0000}},
      '{'{32'h01234567, hbad_pkg::SIZE_HALF, ACT_READ, 16'h0000}, 1'b1,
        '{hbad_pkg::RG_UNMAPPED, 25'h0000000, 2'd0, 2'd0, 1'b0, 16'h0000}},
      '{'{32'h04000202, hbad_pkg::SIZE_HALF, ACT_WRITE, 16'hFFFF}, 1'b1,
        '{hbad_pkg::RG_INTR, 25'h0000002, 2'd0, 2'd0, 1'b1, 16'hFFFF}},
      '{'{32'h04000202, hbad_pkg::SIZE_BYTE, ACT_WRITE, 16'hABCD}, 1'b1,
        '{hbad_pkg::RG_INTR, 25'h0000002, 2'd0, 2'd0, 1'b1, 16'h00CD}},
      '{'{32'h09FFFFFF, hbad_pkg::SIZE_BYTE, ACT_READ, 16'h0000}, 1'b1,
        '{hbad_pkg::RG_ROM, 25'h1FFFFFF, 2'd0, 2'd0, 1'b1, 16'h0000}},
      '{'{32'h0DFFFFFF, SIZE_SPARE, ACT_READ, 16'h0000}, 1'b1,
        '{hbad_pkg::RG_ROM, 25'h1FFFFFC, 2'd0, 2'd2, 1'b1, 16'h0000}},
      // I/O sub-region edges, checked against the predictor.
      '{'{32'h04000203, hbad_pkg::SIZE_WORD, ACT_WRITE, 16'h1234}, 1'b0, NO_GOLDEN},
      '{'{32'h04000056, hbad_pkg::SIZE_BYTE, ACT_READ, 16'h0000}, 1'b0, NO_GOLDEN},
      '{'{32'h04000057, hbad_pkg::SIZE_HALF, ACT_READ, 16'h0000}, 1'b0, NO_GOLDEN},
      '{'{32'h040000B0, hbad_pkg::SIZE_HALF, ACT_READ, 16'h0000}, 1'b0, NO_GOLDEN},
      '{'{32'h040000DE, hbad_pkg::SIZE_BYTE, ACT_WRITE, 16'h5555}, 1'b0, NO_GOLDEN},
      '{'{32'h040000C8, hbad_pkg::SIZE_WORD, ACT_READ, 16'h0000}, 1'b0, NO_GOLDEN},
      '{'{32'h0400010F, hbad_pkg::SIZE_BYTE, ACT_READ, 16'h0000}, 1'b0, NO_GOLDEN},
      '{'{32'h04000130, hbad_pkg::SIZE_HALF, ACT_READ, 16'h0000}, 1'b0, NO_GOLDEN},
      '{'{32'h04000134, hbad_pkg::SIZE_HALF, ACT_WRITE, 16'hAAAA}, 1'b0, NO_GOLDEN},
      '{'{32'h04000300, hbad_pkg::SIZE_BYTE, ACT_WRITE, 16'h00FF}, 1'b0, NO_GOLDEN},
      '{'{32'h04AB0800, hbad_pkg::SIZE_WORD, ACT_READ, 16'h0000}, 1'b0, NO_GOLDEN},
      '{'{32'h04000400, hbad_pkg::SIZE_HALF, ACT_READ, 16'h0000}, 1'b0, NO_GOLDEN},
      // Memory mirrors, permissions and ignored upper address bits.
      '{'{32'h05000401, hbad_pkg::SIZE_BYTE, ACT_WRITE, 16'h0000}, 1'b0, NO_GOLDEN},
      '{'{32'h16020000, hbad_pkg::SIZE_HALF, ACT_WRITE, 16'h0000}, 1'b0, NO_GOLDEN},
      '{'{32'h07FFFFFF, hbad_pkg::SIZE_BYTE, ACT_READ, 16'h0000}, 1'b0, NO_GOLDEN},
      '{'{32'h0A000000, hbad_pkg::SIZE_HALF, ACT_WRITE, 16'h0000}, 1'b0, NO_GOLDEN},
      '{'{32'hE2345678, hbad_pkg::SIZE_BYTE, ACT_WRITE, 16'h0000}, 1'b0, NO_GOLDEN},
      '{'{32'h03FFFFFF, hbad_pkg::SIZE_HALF, ACT_READ, 16'h0000}, 1'b0, NO_GOLDEN},
      '{'{32'h0E00FFFF, hbad_pkg::SIZE_BYTE, ACT_WRITE, 16'h0000}, 1'b0, NO_GOLDEN}
   };

   // Low I/O address bits around the sub-region boundaries.
   localparam logic [11:0] IO_PROBES [0:30] = '{
      12'h000, 12'h056, 12'h057, 12'h0AF, 12'h0B0, 12'h0BB, 12'h0BC, 12'h0C7,
      12'h0C8, 12'h0D3, 12'h0D4, 12'h0DE, 12'h0DF, 12'h0FF, 12'h100, 12'h10F,
      12'h110, 12'h12F, 12'h130, 12'h131, 12'h134, 12'h1FF, 12'h200, 12'h202,
      12'h203, 12'h2FF, 12'h300, 12'h3FF, 12'h400, 12'h800, 12'hFFF
   };

   logic clock = 1'b0;
   logic reset;

   hbad_req_if req_bus ();
   hbad_rsp_if rsp_bus ();

   handheld_bus_address_decoder i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   hbad_pkg::rsp_type pending_decodes [$];
   int unsigned       error_count = 0;
   int unsigned       random_sent = 0;
   bit                steady_stretch = 1'b0;
   logic              golden_known = 1'b0;
   hbad_pkg::rsp_type golden_decode = '0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Expected decode of one bus access.
   function automatic hbad_pkg::rsp_type decode_access(input hbad_pkg::req_type r);
      logic [31:0]       a;
      logic [31:0]       off;
      logic [31:0]       chan;
      logic              wr;
      logic              is_byte;
      hbad_pkg::rsp_type res;
      wr = (r.action == ACT_WRITE);
      is_byte = (r.access_size == hbad_pkg::SIZE_BYTE);
      a = r.address;
      // Word accesses (and the spare size code) drop the low address bits.
      if (r.access_size[1]) begin
         a[1:0] = 2'b00;
      end
      a[31:28] = 4'h0;
      res = '0;
      res.region = hbad_pkg::RG_UNMAPPED;
      off = 32'h0;
      case (a[27:24])
         hbad_pkg::PG_BIOS: begin
            res.region = hbad_pkg::RG_BIOS;
            off = a & 32'h00FFFFFF;
            res.allowed = !wr;
         end
         hbad_pkg::PG_EWRAM: begin
            res.region = hbad_pkg::RG_EWRAM;
            off = a & 32'h0003FFFF;
            res.allowed = 1'b1;
         end
         hbad_pkg::PG_IWRAM: begin
            res.region = hbad_pkg::RG_IWRAM;
            off = a & 32'h00007FFF;
            res.allowed = 1'b1;
         end
         hbad_pkg::PG_IO: begin
            res.allowed = 1'b1;
            if (wr && a == 32'h04000202) begin
               // Interrupt flag write: report the bits to clear.
               res.region = hbad_pkg::RG_INTR;
               off = 32'h2;
               res.irq_clear_mask = is_byte ? {8'h00, r.write_data[7:0]} : r.write_data;
            end else if (a <= 32'h04000056) begin
               res.region = hbad_pkg::RG_VIDEO;
               off = a - 32'h04000000;
            end else if (a >= 32'h040000B0 && a <= 32'h040000DE) begin
               chan = (a - 32'h040000B0) / 12;
               res.region = hbad_pkg::RG_DMA;
               res.dma_channel = chan[1:0];
               off = (a & 32'hFF) - 32'hB0 - 12 * chan;
            end else if (a >= 32'h04000100 && a <= 32'h0400010F) begin
               res.region = hbad_pkg::RG_TIMER;
               off = a - 32'h04000100;
            end else if (a == 32'h04000130) begin
               res.region = hbad_pkg::RG_KEYPAD;
            end else if (a == 32'h04000134) begin
               res.region = hbad_pkg::RG_SERIAL;
            end else if (a >= 32'h04000200) begin
               // Bits 11:8 pick the upper I/O blocks; memory control matches its mirrors.
               if (a[11:8] == 4'h2) begin
                  res.region = hbad_pkg::RG_INTR;
                  off = a & 32'hFF;
               end else if (a[11:8] == 4'h3) begin
                  res.region = hbad_pkg::RG_POWER;
                  off = a & 32'hFF;
               end else if ((a & 32'h0F00FFFF) == 32'h04000800) begin
                  res.region = hbad_pkg::RG_MEMCTL;
               end
            end
         end
         hbad_pkg::PG_PALETTE: begin
            res.region = hbad_pkg::RG_PALETTE;
            off = a & 32'h000003FF;
            res.allowed = !(wr && is_byte);
         end
         hbad_pkg::PG_VRAM: begin
            res.region = hbad_pkg::RG_VRAM;
            off = a & 32'h0001FFFF;
            res.allowed = !(wr && is_byte);
         end
         hbad_pkg::PG_OAM: begin
            res.region = hbad_pkg::RG_OAM;
            off = a & 32'h000003FF;
            res.allowed = !(wr && is_byte);
         end
         hbad_pkg::PG_ROM0A, hbad_pkg::PG_ROM0B: begin
            res.region = hbad_pkg::RG_ROM;
            off = a - 32'h08000000;
            res.allowed = !wr;
         end
         hbad_pkg::PG_ROM1A, hbad_pkg::PG_ROM1B: begin
            res.region = hbad_pkg::RG_ROM;
            off = a - 32'h0A000000;
            res.wait_state = 2'd1;
            res.allowed = !wr;
         end
         hbad_pkg::PG_ROM2A, hbad_pkg::PG_ROM2B: begin
            res.region = hbad_pkg::RG_ROM;
            off = a - 32'h0C000000;
            res.wait_state = 2'd2;
            res.allowed = !wr;
         end
         hbad_pkg::PG_SRAMA, hbad_pkg::PG_SRAMB: begin
            res.region = hbad_pkg::RG_SRAM;
            off = a & 32'h0000FFFF;
            res.allowed = is_byte;
         end
         default: begin
            res.region = hbad_pkg::RG_UNMAPPED;
            res.allowed = 1'b0;
         end
      endcase
      res.offset = off[24:0];
      return res;
   endfunction

   // Random access, weighted toward the I/O boundaries and the mirror edges.
   function automatic hbad_pkg::req_type random_access();
      hbad_pkg::req_type r;
      int unsigned       pick;
      r.address = $urandom;
      r.access_size = 2'($urandom_range(0, 3));
      r.action = 1'($urandom_range(0, 1));
      r.write_data = 16'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
         r.address[27:24] = hbad_pkg::PG_IO;
         if (pick < 30) begin
            r.address[11:0] = IO_PROBES[$urandom_range(0, 30)];
         end
         if ($urandom_range(0, 3) != 0) begin
            r.address[23:16] = 8'h00;
         end
         if ($urandom_range(0, 3) != 0) begin
            r.address[15:12] = 4'h0;
         end
         if (r.address[11:0] == 12'h202 && $urandom_range(0, 1) == 1) begin
            r.action = ACT_WRITE;
         end
      end else if (pick < 90) begin
         case ($urandom_range(0, 3))
            0: r.address[23:0] = 24'h000000;
            1: r.address[23:0] = 24'hFFFFFF;
            default: ;
         endcase
      end
      return r;
   endfunction

   // Offer one request and hold it until the decoder takes it.
   task automatic issue_access(input hbad_pkg::req_type r, input logic known,
                               input hbad_pkg::rsp_type golden);
      while (!steady_stretch && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.valid = 1'b1;
      req_bus.address = r.address;
      req_bus.access_size = r.access_size;
      req_bus.action = r.action;
      req_bus.write_data = r.write_data;
      golden_known = known;
      golden_decode = golden;
      do begin
         @(posedge clock);
      end while (!req_bus.ready);
      @(negedge clock);
   endtask

   // Stop offering and wait until every pending decode has come back.
   task automatic drain_decodes();
      req_bus.valid = 1'b0;
      while (pending_decodes.size() != 0) begin
         @(posedge clock);
      end
      @(negedge clock);
   endtask

   // Result side: random stalls, one long hold-off, and a stretch with no stalls.
   initial begin
      int unsigned holdoff_left;
      bit          holdoff_done;
      holdoff_left = 0;
      holdoff_done = 1'b0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (reset) begin
            rsp_bus.ready = 1'b0;
         end else if (holdoff_left != 0) begin
            rsp_bus.ready = 1'b0;
            holdoff_left--;
         end else if (!holdoff_done && random_sent >= HOLDOFF_AT) begin
            holdoff_done = 1'b1;
            holdoff_left = HOLDOFF_CYCLES - 1;
            rsp_bus.ready = 1'b0;
         end else if (steady_stretch) begin
            rsp_bus.ready = 1'b1;
         end else begin
            rsp_bus.ready = ($urandom_range(0, 99) >= IDLE_PERCENT);
         end
      end
   end

   // Predict each accepted request and check each accepted result against the oldest one.
   always @(posedge clock) begin
      hbad_pkg::req_type seen;
      hbad_pkg::rsp_type want;
      hbad_pkg::rsp_type got;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            seen.address = req_bus.address;
            seen.access_size = req_bus.access_size;
            seen.action = req_bus.action;
            seen.write_data = req_bus.write_data;
            pending_decodes.push_back(golden_known ? golden_decode : decode_access(seen));
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.region = rsp_bus.region;
            got.offset = rsp_bus.offset;
            got.dma_channel = rsp_bus.dma_channel;
            got.wait_state = rsp_bus.wait_state;
            got.allowed = rsp_bus.allowed;
            got.irq_clear_mask = rsp_bus.irq_clear_mask;
            if (pending_decodes.size() == 0) begin
               error_count++;
               if (error_count <= MAX_REPORTS) begin
                  $display("%0t: decode result with no request pending: region %0d offset %h",
                           $realtime, got.region, got.offset);
               end
            end else begin
               want = pending_decodes.pop_front();
               if (got.region !== want.region || got.offset !== want.offset ||
                   got.dma_channel !== want.dma_channel ||
                   got.wait_state !== want.wait_state || got.allowed !== want.allowed ||
                   got.irq_clear_mask !== want.irq_clear_mask) begin
                  error_count++;
                  if (error_count <= MAX_REPORTS) begin
                     $display("%0t: expected region %0d offset %h dma %0d wait %0d ok %b clr %h",
                              $realtime, want.region, want.offset, want.dma_channel,
                              want.wait_state, want.allowed, want.irq_clear_mask);
                     $display("%0t:      got region %0d offset %h dma %0d wait %0d ok %b clr %h",
                              $realtime, got.region, got.offset, got.dma_channel,
                              got.wait_state, got.allowed, got.irq_clear_mask);
                  end
               end
            end
         end
      end
   end

   // Watchdog on the total run length.
   initial begin
      int unsigned cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("handheld_bus_address_decoder verification failed");
      $finish;
   end

   // Request side: reset, directed table, random accesses, then the final verdict.
   initial begin
      int unsigned n;
      req_bus.valid = 1'b0;
      req_bus.address = 32'h0;
      req_bus.access_size = hbad_pkg::SIZE_BYTE;
      req_bus.action = ACT_READ;
      req_bus.write_data = 16'h0;
      reset = 1'b1;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (DIRECTED[i]) begin
         issue_access(DIRECTED[i].req, DIRECTED[i].known, DIRECTED[i].golden);
      end
      drain_decodes();

      for (n = 0; n < RANDOM_ITEMS; n++) begin
         steady_stretch = (n >= STEADY_FIRST && n < STEADY_LAST);
         if (n == DRAIN_AT) begin
            drain_decodes();
         end
         issue_access(random_access(), 1'b0, NO_GOLDEN);
         random_sent++;
      end
      steady_stretch = 1'b0;
      drain_decodes();
      repeat (TAIL_CYCLES) @(posedge clock);

      if (error_count == 0 && pending_decodes.size() == 0) begin
         $display("handheld_bus_address_decoder verification clean");
      end else begin
         $display("handheld_bus_address_decoder verification failed");
      end
      $finish;
   end

endmodule
